>>> hw/rtl/sbst_pkg.sv
// shared types and constants for the swept box slab test
`default_nettype none

package sbst_pkg;

    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam logic [1:0] AXIS_CODE [3] = '{AXIS_X, AXIS_Y, AXIS_Z};

    typedef struct packed {
        logic       pen;
        logic       par_miss;
        logic [1:0] pen_axis;
        logic       pen_neg;
    } class_t;

    localparam int CLASS_W = $bits(class_t);

endpackage

`default_nettype wire

>>> hw/rtl/sbst_fifo.sv
// small first-in first-out queue between the front and the back
`default_nettype none

module sbst_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output logic [W-1:0] rd_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/sbst_front.sv
// front end: input capture, box growth and start classification
`default_nettype none

module sbst_front #(
    parameter int C = 32,
    localparam int REC_W = 6 * C + (C - 1) + sbst_pkg::CLASS_W + 6 * (C + 2)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [10*C-5:0]     in_data,
    input  logic signed [C-1:0] box_min [3],
    input  logic signed [C-1:0] box_max [3],
    output logic                rec_valid,
    input  logic                rec_ready,
    output logic [REC_W-1:0]    rec_data
);
    import sbst_pkg::*;

    logic                f1_vld_reg, f2_vld_reg, fen;
    logic [10*C-5:0]     f1_data_reg;
    logic signed [C-1:0] s1 [3];
    logic [C-2:0]        h1 [3];
    logic signed [C-1:0] d1 [3];
    logic signed [C:0]   lo1 [3], hi1 [3];
    logic signed [C-1:0] s2_reg [3], d2_reg [3];
    logic signed [C:0]   lo2_reg [3], hi2_reg [3];
    logic [C-2:0]        maxd2_reg;
    logic signed [C+1:0] nlo [3], nhi [3];
    class_t              cls;

    assign fen       = !f2_vld_reg || rec_ready;
    assign s_tready  = fen;
    assign rec_valid = f2_vld_reg;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            s1[a]  = f1_data_reg[a*C +: C];
            h1[a]  = f1_data_reg[3*C + a*(C-1) +: C-1];
            d1[a]  = f1_data_reg[6*C-3 + a*C +: C];
            lo1[a] = {box_min[a][C-1], box_min[a]} - {2'b00, h1[a]};
            hi1[a] = {box_max[a][C-1], box_max[a]} + {2'b00, h1[a]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end else if (fen) begin
            f1_vld_reg <= s_tvalid;
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fen) begin
            f1_data_reg <= in_data;
            maxd2_reg   <= f1_data_reg[9*C-3 +: C-1];
            for (int a = 0; a < 3; a++) begin
                s2_reg[a]  <= s1[a];
                d2_reg[a]  <= d1[a];
                lo2_reg[a] <= lo1[a];
                hi2_reg[a] <= hi1[a];
            end
        end
    end

    always_comb begin
        logic signed [C+1:0] se, loe, hie, tmin, tmax, cand, best;
        logic                up, in_slab;
        cls.pen      = 1'b1;
        cls.par_miss = 1'b0;
        cls.pen_axis = AXIS_X;
        cls.pen_neg  = 1'b0;
        best         = '0;
        for (int a = 0; a < 3; a++) begin
            se     = {{2{s2_reg[a][C-1]}}, s2_reg[a]};
            loe    = {lo2_reg[a][C], lo2_reg[a]};
            hie    = {hi2_reg[a][C], hi2_reg[a]};
            nlo[a] = loe - se;
            nhi[a] = hie - se;
            in_slab = !(se < loe) && !(se > hie);
            if (!in_slab) begin
                cls.pen = 1'b0;
                if (d2_reg[a] == '0) begin
                    cls.par_miss = 1'b1;
                end
            end
            tmin = se - loe;
            tmax = nhi[a];
            up   = tmax < tmin;
            cand = up ? tmax : tmin;
            if (a == 0 || cand < best) begin
                best         = cand;
                cls.pen_axis = AXIS_CODE[a];
                cls.pen_neg  = !up;
            end
        end
    end

    assign rec_data = {nhi[2], nhi[1], nhi[0], nlo[2], nlo[1], nlo[0], cls, maxd2_reg,
                       d2_reg[2], d2_reg[1], d2_reg[0], s2_reg[2], s2_reg[1], s2_reg[0]};

endmodule

`default_nettype wire

>>> hw/rtl/sbst_qdiv.sv
// pipelined saturating fixed-point divider, one quotient bit per stage
`default_nettype none

module sbst_qdiv #(
    parameter int C = 32,
    parameter int F = 16
) (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [C+1:0] num,
    input  logic signed [C-1:0] den,
    output logic signed [C+1:0] quo
);
    localparam int NW = C + 1 + F;
    localparam int XW = NW + C + 2;
    localparam int NB = C + 1;

    localparam logic [C:0] LIM = {1'b1, {C{1'b0}}};

    logic [C+1:0]  num_mag;
    logic [C-1:0]  den_mag;
    logic [C:0]    n_a_reg;
    logic [C-1:0]  d_a_reg;
    logic          neg_a_reg;
    logic [XW-1:0] rem_reg [NB+1];
    logic [XW-1:0] rem_next [NB+1];
    logic [C:0]    q_reg [NB+1];
    logic [C:0]    q_next [NB+1];
    logic [C-1:0]  dv_reg [NB+1];
    logic          ovf_reg [NB+1];
    logic          ng_reg [NB+1];
    logic          ovf0;
    logic [C:0]    mag;

    assign num_mag = num[C+1] ? (~num + 1'b1) : num;
    assign den_mag = den[C-1] ? (~den + 1'b1) : den;

    always_comb begin
        logic [XW-1:0] trial;
        rem_next[0] = {{(XW-NW){1'b0}}, n_a_reg, {F{1'b0}}};
        q_next[0]   = '0;
        ovf0 = rem_next[0] >= ({{(XW-C){1'b0}}, d_a_reg} << NB);
        for (int j = 1; j <= NB; j++) begin
            trial = {{(XW-C){1'b0}}, dv_reg[j-1]} << (NB - j);
            if (rem_reg[j-1] >= trial) begin
                rem_next[j] = rem_reg[j-1] - trial;
                q_next[j]   = q_reg[j-1] | ({{C{1'b0}}, 1'b1} << (NB - j));
            end else begin
                rem_next[j] = rem_reg[j-1];
                q_next[j]   = q_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_a_reg    <= num_mag[C:0];
            d_a_reg    <= den_mag;
            neg_a_reg  <= num[C+1] != den[C-1];
            rem_reg[0] <= rem_next[0];
            q_reg[0]   <= q_next[0];
            dv_reg[0]  <= d_a_reg;
            ovf_reg[0] <= ovf0;
            ng_reg[0]  <= neg_a_reg;
            for (int j = 1; j <= NB; j++) begin
                rem_reg[j] <= rem_next[j];
                q_reg[j]   <= q_next[j];
                dv_reg[j]  <= dv_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
                ng_reg[j]  <= ng_reg[j-1];
            end
        end
    end

    assign mag = (ovf_reg[NB] || q_reg[NB] > LIM) ? LIM : q_reg[NB];
    assign quo = ng_reg[NB] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

`default_nettype wire

>>> hw/rtl/sbst_back.sv
// back end: slab divisions, entry selection, end point and contact clamp
`default_nettype none

module sbst_back #(
    parameter int C = 32,
    parameter int F = 16,
    localparam int REC_W = 6 * C + (C - 1) + sbst_pkg::CLASS_W + 6 * (C + 2),
    localparam int ODW = ((7 * C + 2 + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rd_valid,
    output logic                rd_ready,
    input  logic [REC_W-1:0]    rec_data,
    input  logic signed [C-1:0] box_min [3],
    input  logic signed [C-1:0] box_max [3],
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [ODW-1:0]      m_tdata,
    output logic [1:0]          m_tuser
);
    import sbst_pkg::*;

    localparam int LAT = C + 3;
    localparam int NS  = LAT + 6;
    localparam int SBW = 7 * C - 1 + CLASS_W;
    localparam int OW  = 7 * C + 2;

    localparam logic signed [C+1:0] MAXC = {3'b000, {(C-1){1'b1}}};
    localparam logic signed [C+1:0] MINC = {3'b111, {(C-1){1'b0}}};
    localparam logic [C:0]          LIM  = {1'b1, {C{1'b0}}};

    logic                en, pop;
    logic [NS-1:0]       vld_reg;
    logic signed [C+1:0] quo [6];
    logic [SBW-1:0]      sb_reg [LAT];
    logic [SBW-1:0]      sb1_reg, sb2_reg;

    logic signed [C+1:0] nr1_reg [3], fr1_reg [3];
    logic                ng1_reg [3];
    logic signed [C+1:0] nr1_next [3], fr1_next [3];
    logic                ng1_next [3];

    logic signed [C+1:0] enter2_reg, leave2_reg, enter2_next, leave2_next;
    logic [1:0]          axis2_reg, axis2_next;
    logic                neg2_reg, neg2_next;

    class_t              cls2;
    logic [C-2:0]        dist3_reg;
    logic                miss3_reg, pen3_reg, neg3_reg;
    logic [1:0]          axis3_reg;
    logic signed [C-1:0] s3_reg [3];
    logic [C-1:0]        dmag3_reg [3];
    logic                dneg3_reg [3];

    logic [2*C-2:0]      prod4_reg [3];
    logic [C-2:0]        dist4_reg;
    logic                miss4_reg, pen4_reg, neg4_reg;
    logic [1:0]          axis4_reg;
    logic signed [C-1:0] s4_reg [3];
    logic                dneg4_reg [3];

    logic signed [C-1:0] endp5_reg [3], endp5_next [3];
    logic [C-2:0]        dist5_reg;
    logic                miss5_reg, pen5_reg, neg5_reg;
    logic [1:0]          axis5_reg;

    logic [ODW-1:0]      out_data_reg, out_data_next;
    logic [1:0]          out_user_reg, out_user_next;

    assign en       = !vld_reg[NS-1] || m_tready;
    assign rd_ready = en;
    assign pop      = en && rd_valid;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        sbst_qdiv #(.C(C), .F(F)) u_div_lo (
            .aclk (aclk),
            .en   (en),
            .num  (rec_data[SBW + g*(C+2) +: C+2]),
            .den  (rec_data[3*C + g*C +: C]),
            .quo  (quo[2*g])
        );
        sbst_qdiv #(.C(C), .F(F)) u_div_hi (
            .aclk (aclk),
            .en   (en),
            .num  (rec_data[SBW + 3*(C+2) + g*(C+2) +: C+2]),
            .den  (rec_data[3*C + g*C +: C]),
            .quo  (quo[2*g+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], pop};
        end
    end

    // slab near and far distances
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (quo[2*a] > quo[2*a+1]) begin
                nr1_next[a] = quo[2*a+1];
                fr1_next[a] = quo[2*a];
                ng1_next[a] = 1'b0;
            end else begin
                nr1_next[a] = quo[2*a];
                fr1_next[a] = quo[2*a+1];
                ng1_next[a] = 1'b1;
            end
        end
    end

    // entry and exit over the three slabs
    always_comb begin
        logic [C-1:0] dv;
        enter2_next = '0;
        leave2_next = {3'b000, sb1_reg[6*C +: C-1]};
        axis2_next  = AXIS_Y;
        neg2_next   = 1'b0;
        for (int a = 0; a < 3; a++) begin
            dv = sb1_reg[3*C + a*C +: C];
            if (dv != '0) begin
                if (nr1_reg[a] > enter2_next) begin
                    enter2_next = nr1_reg[a];
                    axis2_next  = AXIS_CODE[a];
                    neg2_next   = ng1_reg[a];
                end
                if (fr1_reg[a] < leave2_next) begin
                    leave2_next = fr1_reg[a];
                end
            end
        end
    end

    assign cls2 = sb2_reg[7*C-1 +: CLASS_W];

    // end point: start plus saturated direction times distance
    always_comb begin
        logic [2*C-2:0]      sh;
        logic [C:0]          mag;
        logic signed [C+1:0] mul, sum;
        for (int a = 0; a < 3; a++) begin
            sh  = prod4_reg[a] >> F;
            mag = (sh[2*C-2:C] != '0) ? LIM : sh[C:0];
            mul = dneg4_reg[a] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            sum = $signed({{2{s4_reg[a][C-1]}}, s4_reg[a]}) + mul;
            if (sum > MAXC) begin
                endp5_next[a] = MAXC[C-1:0];
            end else if (sum < MINC) begin
                endp5_next[a] = MINC[C-1:0];
            end else begin
                endp5_next[a] = sum[C-1:0];
            end
        end
    end

    always_comb begin
        logic [OW-1:0]       data;
        logic signed [C-1:0] pt [3];
        for (int a = 0; a < 3; a++) begin
            if (endp5_reg[a] < box_min[a]) begin
                pt[a] = box_min[a];
            end else if (endp5_reg[a] > box_max[a]) begin
                pt[a] = box_max[a];
            end else begin
                pt[a] = endp5_reg[a];
            end
        end
        data = {pt[2], pt[1], pt[0], neg5_reg, axis5_reg,
                endp5_reg[2], endp5_reg[1], endp5_reg[0], dist5_reg};
        out_data_next = '0;
        out_user_next = '0;
        if (!miss5_reg) begin
            out_data_next[OW-1:0] = data;
            out_user_next         = {pen5_reg, 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_reg[0] <= rec_data[SBW-1:0];
            for (int i = 1; i < LAT; i++) begin
                sb_reg[i] <= sb_reg[i-1];
            end

            sb1_reg <= sb_reg[LAT-1];
            for (int a = 0; a < 3; a++) begin
                nr1_reg[a] <= nr1_next[a];
                fr1_reg[a] <= fr1_next[a];
                ng1_reg[a] <= ng1_next[a];
            end

            sb2_reg    <= sb1_reg;
            enter2_reg <= enter2_next;
            leave2_reg <= leave2_next;
            axis2_reg  <= axis2_next;
            neg2_reg   <= neg2_next;

            pen3_reg  <= cls2.pen;
            miss3_reg <= !cls2.pen && (cls2.par_miss || (enter2_reg > leave2_reg));
            dist3_reg <= cls2.pen ? '0 : enter2_reg[C-2:0];
            axis3_reg <= cls2.pen ? cls2.pen_axis : axis2_reg;
            neg3_reg  <= cls2.pen ? cls2.pen_neg : neg2_reg;
            for (int a = 0; a < 3; a++) begin
                s3_reg[a]    <= sb2_reg[a*C +: C];
                dmag3_reg[a] <= sb2_reg[3*C + a*C + C - 1] ?
                                (~sb2_reg[3*C + a*C +: C] + 1'b1) : sb2_reg[3*C + a*C +: C];
                dneg3_reg[a] <= sb2_reg[3*C + a*C + C - 1];
            end

            dist4_reg <= dist3_reg;
            miss4_reg <= miss3_reg;
            pen4_reg  <= pen3_reg;
            axis4_reg <= axis3_reg;
            neg4_reg  <= neg3_reg;
            for (int a = 0; a < 3; a++) begin
                prod4_reg[a] <= {{(C-1){1'b0}}, dmag3_reg[a]} * {{C{1'b0}}, dist3_reg};
                s4_reg[a]    <= s3_reg[a];
                dneg4_reg[a] <= dneg3_reg[a];
            end

            dist5_reg <= dist4_reg;
            miss5_reg <= miss4_reg;
            pen5_reg  <= pen4_reg;
            axis5_reg <= axis4_reg;
            neg5_reg  <= neg4_reg;
            for (int a = 0; a < 3; a++) begin
                endp5_reg[a] <= endp5_next[a];
            end

            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

>>> hw/rtl/swept_box_slab_test_core.sv
// top level: swept box against one configured target box, Q16.16 by default
// throughput: one transaction per cycle while the result is not stalled, set by the bit-per-stage slab dividers
// the result register stalls the back pipe; the queue lets the front keep accepting until it fills
// reset: synchronous active-low aresetn clears all valid state and the box registers
`default_nettype none

module swept_box_slab_test_core #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    localparam int IDW = ((10 * COORD_WIDTH - 4 + 7) / 8) * 8,
    localparam int ODW = ((7 * COORD_WIDTH + 2 + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [sbst_pkg::REG_IDX_W-1:0] cfg_addr,
    input  logic [COORD_WIDTH-1:0]         cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // start_x, start_y, start_z, half_x, half_y, half_z, dir_x, dir_y, dir_z, max_distance
    input  logic [IDW-1:0]                 s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // distance, end_x, end_y, end_z, normal_axis, normal_negative, point_x, point_y, point_z
    output logic [ODW-1:0]                 m_tdata,
    // hit, start_penetrating
    output logic [1:0]                     m_tuser
);
    import sbst_pkg::*;

    localparam int C     = COORD_WIDTH;
    localparam int REC_W = 6 * C + (C - 1) + CLASS_W + 6 * (C + 2);

    logic signed [C-1:0] box_min_reg [3];
    logic signed [C-1:0] box_max_reg [3];
    logic                rec_valid, rec_ready;
    logic [REC_W-1:0]    rec_data;
    logic                q_valid, q_ready;
    logic [REC_W-1:0]    q_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                box_min_reg[a] <= '0;
                box_max_reg[a] <= '0;
            end
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_BOX_MIN_X: box_min_reg[0] <= cfg_wdata;
                REG_BOX_MIN_Y: box_min_reg[1] <= cfg_wdata;
                REG_BOX_MIN_Z: box_min_reg[2] <= cfg_wdata;
                REG_BOX_MAX_X: box_max_reg[0] <= cfg_wdata;
                REG_BOX_MAX_Y: box_max_reg[1] <= cfg_wdata;
                REG_BOX_MAX_Z: box_max_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    sbst_front #(.C(C)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .in_data   (s_tdata[10*C-5:0]),
        .box_min   (box_min_reg),
        .box_max   (box_max_reg),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec_data  (rec_data)
    );

    sbst_fifo #(.W(REC_W), .DEPTH(4)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (rec_valid),
        .wr_ready (rec_ready),
        .wr_data  (rec_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    sbst_back #(.C(C), .F(FRAC_BITS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rec_data (q_data),
        .box_min  (box_min_reg),
        .box_max  (box_max_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

>>> hw/rtl/sbst_checker.sv
// port-level assertions for the swept box slab test, bound to the top level
`default_nettype none

module sbst_checker #(
    parameter int C = 32,
    localparam int ODW = ((7 * C + 2 + 7) / 8) * 8
) (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_tvalid,
    input logic           m_tready,
    input logic [ODW-1:0] m_tdata,
    input logic [1:0]     m_tuser
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
        else $error("miss with nonzero fields");

    a_pen_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tdata[C-2:0] == '0)
        else $error("penetrating result without hit or with distance");

endmodule

bind swept_box_slab_test_core sbst_checker #(.C(COORD_WIDTH)) u_sbst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
